// ===== rtl/core/sfla_pkg.sv =====
// ---------------------------------------------------------------------------
// sfla_pkg
// Shared types, constants and the size-class map of the heap allocator.
// ---------------------------------------------------------------------------
package sfla_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int NWORDS     = HEAP_BYTES / 4;
    localparam int AW         = $clog2(NWORDS);
    localparam int BRK_W      = $clog2(HEAP_BYTES + 1);
    localparam int NCLASS     = 24;
    localparam int CLS_W      = $clog2(NCLASS);
    localparam int NLIMITS    = 19;
    localparam int STEP_MAX   = HEAP_BYTES / 16;
    localparam int STEP_W     = $clog2(STEP_MAX + 1);

    localparam logic [31:0] HEAP_B32     = 32'(HEAP_BYTES);
    localparam logic [31:0] LINK_BASE    = 32'd104;
    localparam logic [31:0] FIRST_BP     = 32'd112;
    localparam logic [31:0] FIRST_CHUNK  = 32'd992;
    localparam logic [31:0] MIN_EXTEND   = 32'd224;
    localparam logic [31:0] MIN_BLOCK    = 32'd16;
    localparam logic [31:0] PRO_HDR_ADDR = 32'd100;
    localparam logic [31:0] PRO_FTR_ADDR = 32'd104;
    localparam logic [31:0] EPI_ADDR     = 32'd108;
    localparam logic [31:0] PRO_TAG      = 32'd9;
    localparam logic [31:0] EPI_TAG      = 32'd3;

    localparam logic [31:0] CLASS_LIMIT [NLIMITS] = '{
        32'd16, 32'd24, 32'd48, 32'd128, 32'd256, 32'd512, 32'd1024, 32'd2048,
        32'd4096, 32'd9200, 32'd12000, 32'd16000, 32'd20000, 32'd24000,
        32'd28000, 32'd32000, 32'd40000, 32'd32768, 32'd65536
    };

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NULL  = 2'd1;
    localparam logic [1:0] ST_OOM   = 2'd2;
    localparam logic [1:0] ST_FREE  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [16:0] req_bytes;
        logic [15:0] block_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] addr;
        logic [1:0]  status;
    } t_res;

    function automatic logic [CLS_W-1:0] class_of(input logic [31:0] size);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NCLASS - 1);
        for (int i = NLIMITS - 1; i >= 0; i--) begin
            if (size <= CLASS_LIMIT[i]) begin
                c = CLS_W'(i);
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sfla_core.sv =====
// ---------------------------------------------------------------------------
// sfla_core
// Heap memory, class heads and the sequencer that runs allocate and free.
// ---------------------------------------------------------------------------
module sfla_core import sfla_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    output logic o_res_valid,
    output t_res o_res,
    input  logic i_res_ready
);

    typedef enum logic [6:0] {
        S_CLEAR, S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_M0, S_M1,
        S_FF0, S_FF1, S_FF2, S_FF3, S_MEXT,
        S_EX0, S_EX1, S_EX2, S_EX3,
        S_C0, S_C1, S_C2, S_C3,
        S_CA1, S_CA2, S_CA3, S_CA4,
        S_CB1, S_CB2, S_CB3, S_CB4, S_CB5,
        S_CD1, S_CD2, S_CD3, S_CD4, S_CD5, S_CD6, S_CD7,
        S_LI0, S_LI1, S_LI2, S_LI3, S_LI4,
        S_LD0, S_LD1, S_LD2, S_LD3, S_LD4,
        S_P0, S_P1, S_P2,
        S_PS0, S_PS1, S_PS2, S_PS3, S_PS4, S_PS5, S_PS6, S_PS7,
        S_PN0, S_PN1, S_PN2, S_MOK,
        S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
        S_DONE
    } t_state;

    t_state r_state, r_ret_leaf, r_ret_co;

    logic [31:0]       r_mem [NWORDS];
    logic [31:0]       r_mem_q;
    logic              r_rd_ok;
    logic [AW-1:0]     r_clr;
    logic [BRK_W-1:0]  r_brk;
    logic [31:0]       r_heads [NCLASS];
    t_req              r_req;
    t_res              r_res;
    logic [31:0]       r_asize, r_bytes, r_bp, r_nxt, r_prv, r_size, r_tmp;
    logic [31:0]       r_x, r_n, r_p, r_link;
    logic [CLS_W-1:0]  r_c;
    logic [STEP_W-1:0] r_steps;
    logic              r_pa, r_na;

    logic              m_re, m_we, m_ok;
    logic [31:0]       m_addr, m_wdata;
    logic [AW-1:0]     m_idx;
    logic [31:0]       rd_word, blk_size, brk32, n_asize, n_extsz;
    logic              ext_fail, fr_ok0, fr_ok1, walk_go, split_ok;
    logic [32:0]       fr_end;

    assign rd_word  = r_rd_ok ? r_mem_q : 32'd0;
    assign blk_size = {rd_word[31:3], 3'b000};
    assign brk32    = 32'(r_brk);
    assign ext_fail = ({1'b0, brk32} + {1'b0, r_bytes}) > {1'b0, HEAP_B32};
    assign fr_ok0   = (r_req.block_addr != 16'd0) && (r_req.block_addr[2:0] == 3'd0)
                   && (32'(r_req.block_addr) >= FIRST_BP)
                   && (32'(r_req.block_addr) < brk32);
    assign fr_end   = {1'b0, r_bp} - 33'd4 + {1'b0, blk_size};
    assign fr_ok1   = rd_word[0] && (blk_size >= MIN_BLOCK)
                   && (fr_end <= ({1'b0, brk32} - 33'd4));
    assign walk_go  = (r_link != 32'd0) && (r_steps < STEP_W'(STEP_MAX));
    assign split_ok = (r_size >= r_asize) && ((r_size - r_asize) >= MIN_BLOCK);
    assign n_asize  = (r_req.req_bytes <= 17'd8) ? MIN_BLOCK
                    : ((32'(r_req.req_bytes) + 32'd11) & ~32'd7);
    assign n_extsz  = (r_asize > MIN_EXTEND) ? r_asize : MIN_EXTEND;

    assign m_ok  = m_addr < HEAP_B32;
    assign m_idx = m_addr[AW+1:2];

    always_comb begin
        m_re    = 1'b0;
        m_we    = 1'b0;
        m_addr  = 32'd0;
        m_wdata = 32'd0;
        unique case (r_state)
            S_CLEAR: begin
                m_we   = 1'b1;
                m_addr = 32'({r_clr, 2'b00});
            end
            S_INIT0: begin m_we = 1'b1; m_addr = PRO_HDR_ADDR; m_wdata = PRO_TAG; end
            S_INIT1: begin m_we = 1'b1; m_addr = PRO_FTR_ADDR; m_wdata = PRO_TAG; end
            S_INIT2: begin m_we = 1'b1; m_addr = EPI_ADDR; m_wdata = EPI_TAG; end
            S_FF1: begin m_re = walk_go; m_addr = r_link + LINK_BASE - 32'd4; end
            S_FF2: begin m_re = blk_size < r_asize; m_addr = r_bp; end
            S_EX0: begin m_re = !ext_fail; m_addr = brk32 - 32'd4; end
            S_EX1: begin
                m_we = 1'b1; m_addr = r_bp - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_bytes;
            end
            S_EX2: begin m_we = 1'b1; m_addr = r_bp + r_bytes - 32'd8; m_wdata = r_bytes; end
            S_EX3: begin m_we = 1'b1; m_addr = r_bp + r_bytes - 32'd4; m_wdata = 32'd1; end
            S_C0:  begin m_re = 1'b1; m_addr = r_bp - 32'd4; end
            S_C1:  begin m_re = 1'b1; m_addr = r_bp + blk_size - 32'd4; end
            S_C2:  begin m_re = 1'b1; m_addr = r_bp - 32'd8; end
            S_CA1: begin m_re = 1'b1; m_addr = r_nxt - 32'd4; end
            S_CA2: begin m_re = 1'b1; m_addr = r_bp - 32'd4; end
            S_CA3: begin
                m_we = 1'b1; m_addr = r_bp - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_size;
            end
            S_CA4: begin m_we = 1'b1; m_addr = r_bp + r_size - 32'd8; m_wdata = r_size; end
            S_CB1: begin m_re = 1'b1; m_addr = r_prv - 32'd4; end
            S_CB2: begin m_re = 1'b1; m_addr = r_bp - 32'd4; end
            S_CB3: begin m_we = 1'b1; m_addr = r_bp + blk_size - 32'd8; m_wdata = r_size; end
            S_CB4: begin m_re = 1'b1; m_addr = r_prv - 32'd4; end
            S_CB5, S_CD7: begin
                m_we = 1'b1; m_addr = r_prv - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_size;
            end
            S_CD2: begin m_re = 1'b1; m_addr = r_prv - 32'd4; end
            S_CD3: begin m_re = 1'b1; m_addr = r_nxt - 32'd4; end
            S_CD5: begin m_we = 1'b1; m_addr = r_nxt + r_tmp - 32'd8; m_wdata = r_size; end
            S_CD6: begin m_re = 1'b1; m_addr = r_prv - 32'd4; end
            S_LI0: begin m_re = 1'b1; m_addr = r_x - 32'd4; end
            S_LI2: begin m_we = 1'b1; m_addr = r_x; m_wdata = r_heads[r_c]; end
            S_LI3: begin m_we = 1'b1; m_addr = r_x + 32'd4; end
            S_LI4: begin
                m_we    = r_heads[r_c] != 32'd0;
                m_addr  = r_heads[r_c] + LINK_BASE + 32'd4;
                m_wdata = r_x - LINK_BASE;
            end
            S_LD0: begin m_re = 1'b1; m_addr = r_x - 32'd4; end
            S_LD1: begin m_re = 1'b1; m_addr = r_x; end
            S_LD2: begin m_re = 1'b1; m_addr = r_x + 32'd4; end
            S_LD3: begin
                m_we = rd_word != 32'd0; m_addr = rd_word + LINK_BASE; m_wdata = r_n;
            end
            S_LD4: begin
                m_we = r_n != 32'd0; m_addr = r_n + LINK_BASE + 32'd4; m_wdata = r_p;
            end
            S_P0, S_P2: begin m_re = 1'b1; m_addr = r_bp - 32'd4; end
            S_PS0: begin
                m_we = 1'b1; m_addr = r_bp - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_asize | 32'd1;
            end
            S_PS1, S_PS3: begin m_re = 1'b1; m_addr = r_nxt - 32'd4; end
            S_PS2: begin m_we = 1'b1; m_addr = r_nxt - 32'd4; m_wdata = rd_word | 32'd2; end
            S_PS4: begin
                m_we = 1'b1; m_addr = r_nxt - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_tmp;
            end
            S_PS5: begin m_we = 1'b1; m_addr = r_nxt + r_tmp - 32'd8; m_wdata = r_tmp; end
            S_PS6: begin m_re = 1'b1; m_addr = r_nxt + r_tmp - 32'd4; end
            S_PS7: begin
                m_we = 1'b1; m_addr = r_nxt + r_tmp - 32'd4; m_wdata = rd_word & ~32'd2;
            end
            S_PN0: begin
                m_we = 1'b1; m_addr = r_bp - 32'd4;
                m_wdata = (rd_word & 32'd2) | r_size | 32'd1;
            end
            S_PN1: begin m_re = 1'b1; m_addr = r_bp + r_size - 32'd4; end
            S_PN2: begin
                m_we = 1'b1; m_addr = r_bp + r_size - 32'd4; m_wdata = rd_word | 32'd2;
            end
            S_FR0: begin m_re = fr_ok0; m_addr = 32'(r_req.block_addr) - 32'd4; end
            S_FR1: begin
                m_we = fr_ok1; m_addr = r_bp - 32'd4;
                m_wdata = (rd_word & 32'd2) | blk_size;
            end
            S_FR2: begin m_we = 1'b1; m_addr = r_bp + r_size - 32'd8; m_wdata = r_size; end
            S_FR3: begin m_re = 1'b1; m_addr = r_bp + r_size - 32'd4; end
            S_FR4: begin
                m_we = 1'b1; m_addr = r_bp + r_size - 32'd4; m_wdata = rd_word & ~32'd2;
            end
            default: begin
                m_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we && m_ok) begin
            r_mem[m_idx] <= m_wdata;
        end
        r_mem_q <= r_mem[m_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ret_leaf <= S_IDLE;
            r_ret_co   <= S_IDLE;
            r_clr      <= '0;
            r_brk      <= '0;
            r_rd_ok    <= 1'b0;
            r_steps    <= '0;
            for (int i = 0; i < NCLASS; i++) begin
                r_heads[i] <= 32'd0;
            end
        end else begin
            r_rd_ok <= m_re && m_ok;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NWORDS - 1)) begin
                        r_state <= S_INIT0;
                    end
                end
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: r_state <= S_INIT2;
                S_INIT2: begin
                    r_brk    <= BRK_W'(FIRST_BP);
                    r_bytes  <= FIRST_CHUNK;
                    r_ret_co <= S_IDLE;
                    r_state  <= S_EX0;
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= (i_req.cmd == CMD_FREE) ? S_FR0 : S_M0;
                    end
                end
                S_M0: begin
                    r_res.addr <= 16'd0;
                    if (r_req.req_bytes == 17'd0) begin
                        r_res.status <= ST_NULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_asize <= n_asize;
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_c     <= class_of(r_asize);
                    r_state <= S_FF0;
                end
                S_FF0: begin
                    r_link  <= r_heads[r_c];
                    r_steps <= '0;
                    r_state <= S_FF1;
                end
                S_FF1: begin
                    if (walk_go) begin
                        r_bp    <= r_link + LINK_BASE;
                        r_state <= S_FF2;
                    end else if (r_c == CLS_W'(NCLASS - 1)) begin
                        r_state <= S_MEXT;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_FF0;
                    end
                end
                S_FF2: r_state <= (blk_size >= r_asize) ? S_P0 : S_FF3;
                S_FF3: begin
                    r_link  <= rd_word;
                    r_steps <= r_steps + 1'b1;
                    r_state <= S_FF1;
                end
                S_MEXT: begin
                    r_bytes  <= n_extsz;
                    r_ret_co <= S_P0;
                    r_state  <= S_EX0;
                end
                S_EX0: begin
                    if (ext_fail) begin
                        r_res.status <= ST_OOM;
                        r_state      <= S_DONE;
                    end else begin
                        r_bp    <= brk32;
                        r_state <= S_EX1;
                    end
                end
                S_EX1: r_state <= S_EX2;
                S_EX2: r_state <= S_EX3;
                S_EX3: begin
                    r_brk   <= BRK_W'(brk32 + r_bytes);
                    r_state <= S_C0;
                end
                S_C0: r_state <= S_C1;
                S_C1: begin
                    r_size  <= blk_size;
                    r_pa    <= rd_word[1];
                    r_nxt   <= r_bp + blk_size;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_na    <= rd_word[0];
                    r_state <= S_C3;
                end
                S_C3: begin
                    r_prv <= r_bp - blk_size;
                    priority if (r_pa && r_na) begin
                        r_x        <= r_bp;
                        r_ret_leaf <= r_ret_co;
                        r_state    <= S_LI0;
                    end else if (r_pa) begin
                        r_x        <= r_nxt;
                        r_ret_leaf <= S_CA1;
                        r_state    <= S_LD0;
                    end else if (r_na) begin
                        r_x        <= r_bp - blk_size;
                        r_ret_leaf <= S_CB1;
                        r_state    <= S_LD0;
                    end else begin
                        r_x        <= r_bp - blk_size;
                        r_ret_leaf <= S_CD1;
                        r_state    <= S_LD0;
                    end
                end
                S_CA1: r_state <= S_CA2;
                S_CA2: begin
                    r_size  <= r_size + blk_size;
                    r_state <= S_CA3;
                end
                S_CA3: r_state <= S_CA4;
                S_CA4: begin
                    r_x        <= r_bp;
                    r_ret_leaf <= r_ret_co;
                    r_state    <= S_LI0;
                end
                S_CB1: r_state <= S_CB2;
                S_CB2: begin
                    r_size  <= r_size + blk_size;
                    r_state <= S_CB3;
                end
                S_CB3: r_state <= S_CB4;
                S_CB4: r_state <= S_CB5;
                S_CB5, S_CD7: begin
                    r_bp       <= r_prv;
                    r_x        <= r_prv;
                    r_ret_leaf <= r_ret_co;
                    r_state    <= S_LI0;
                end
                S_CD1: begin
                    r_x        <= r_nxt;
                    r_ret_leaf <= S_CD2;
                    r_state    <= S_LD0;
                end
                S_CD2: r_state <= S_CD3;
                S_CD3: begin
                    r_tmp   <= blk_size;
                    r_state <= S_CD4;
                end
                S_CD4: begin
                    r_size  <= r_size + r_tmp + blk_size;
                    r_tmp   <= blk_size;
                    r_state <= S_CD5;
                end
                S_CD5: r_state <= S_CD6;
                S_CD6: r_state <= S_CD7;
                S_LI0: r_state <= S_LI1;
                S_LI1: begin
                    r_c     <= class_of(blk_size);
                    r_state <= S_LI2;
                end
                S_LI2: r_state <= S_LI3;
                S_LI3: r_state <= S_LI4;
                S_LI4: begin
                    r_heads[r_c] <= r_x - LINK_BASE;
                    r_state      <= r_ret_leaf;
                end
                S_LD0: r_state <= S_LD1;
                S_LD1: begin
                    r_c     <= class_of(blk_size);
                    r_state <= S_LD2;
                end
                S_LD2: begin
                    r_n     <= rd_word;
                    r_state <= S_LD3;
                end
                S_LD3: begin
                    r_p <= rd_word;
                    if (rd_word == 32'd0) begin
                        r_heads[r_c] <= r_n;
                    end
                    r_state <= S_LD4;
                end
                S_LD4: r_state <= r_ret_leaf;
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_size     <= blk_size;
                    r_x        <= r_bp;
                    r_ret_leaf <= S_P2;
                    r_state    <= S_LD0;
                end
                S_P2: begin
                    r_tmp   <= r_size - r_asize;
                    r_nxt   <= r_bp + r_asize;
                    r_state <= split_ok ? S_PS0 : S_PN0;
                end
                S_PS0: r_state <= S_PS1;
                S_PS1: r_state <= S_PS2;
                S_PS2: r_state <= S_PS3;
                S_PS3: r_state <= S_PS4;
                S_PS4: r_state <= S_PS5;
                S_PS5: r_state <= S_PS6;
                S_PS6: r_state <= S_PS7;
                S_PS7: begin
                    r_x        <= r_nxt;
                    r_ret_leaf <= S_MOK;
                    r_state    <= S_LI0;
                end
                S_PN0: r_state <= S_PN1;
                S_PN1: r_state <= S_PN2;
                S_PN2: r_state <= S_MOK;
                S_MOK: begin
                    r_res.addr   <= r_bp[15:0];
                    r_res.status <= ST_ALLOC;
                    r_state      <= S_DONE;
                end
                S_FR0: begin
                    r_res.addr   <= 16'd0;
                    r_res.status <= ST_FREE;
                    r_bp         <= 32'(r_req.block_addr);
                    r_state      <= fr_ok0 ? S_FR1 : S_DONE;
                end
                S_FR1: begin
                    r_size  <= blk_size;
                    r_state <= fr_ok1 ? S_FR2 : S_DONE;
                end
                S_FR2: r_state <= S_FR3;
                S_FR3: r_state <= S_FR4;
                S_FR4: begin
                    r_ret_co <= S_DONE;
                    r_state  <= S_C0;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_res       = r_res;

    a_ready_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_res_valid))
        else $error("request and result side open together");

    a_brk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        brk32 <= HEAP_B32)
        else $error("heap break beyond heap");

    a_brk_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk[2:0] == 3'd0)
        else $error("heap break not 8-byte aligned");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(STEP_MAX))
        else $error("free-list walk exceeded its bound");

endmodule

// ===== rtl/core/segregated_free_list_allocator_top.sv =====
// ---------------------------------------------------------------------------
// segregated_free_list_allocator_top
// Heap allocator: malloc/free over a word memory with segregated free lists.
// A free or an allocate runs as a sequence of heap memory accesses before its
// result reaches o_m_tvalid; an allocate also walks the free lists node by node.
// One transaction at a time; the single-port heap memory sets the pace.
// Reset: after i_rst_n the heap memory is cleared for HEAP_BYTES/4 cycles
// (16384) and the initial layout is written; o_s_tready stays low meanwhile.
// ---------------------------------------------------------------------------
module segregated_free_list_allocator_top import sfla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // req_bytes[16:0], block_addr[32:17], zero fill
    input  logic        i_s_tuser,   // cmd[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // addr[15:0]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    t_req core_req;
    t_res core_res;
    logic core_res_valid, core_res_ready;
    logic r_out_valid;
    t_res r_out;

    assign core_req.cmd        = i_s_tuser;
    assign core_req.req_bytes  = i_s_tdata[16:0];
    assign core_req.block_addr = i_s_tdata[32:17];

    sfla_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req       (core_req),
        .o_req_ready (o_s_tready),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .i_res_ready (core_res_ready)
    );

    assign core_res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_ready) begin
            r_out_valid <= core_res_valid;
            if (core_res_valid) begin
                r_out <= core_res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.addr;
    assign o_m_tuser  = r_out.status;

endmodule
